// ===== src/dci_pkg.sv =====
// Shared types and constants of the delta copy/insert matcher.
`timescale 1ns / 1ps
package dci_pkg;

  // Default capacity of each byte buffer and the copy threshold.
  localparam int MAX_BYTES = 4096;
  localparam int MIN_BEAT  = 4;
  // Number of match cells in the row; one pass covers this many old offsets.
  localparam int NUM_CELLS = 16;

  // Fixed port widths.
  localparam int CMD_W  = 2;
  localparam int KIND_W = 2;
  localparam int POS_W  = 12;
  localparam int LEN_W  = 13;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_LOAD_OLD = 2'd1,
    CMD_LOAD_NEW = 2'd2,
    CMD_REQUEST  = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_COPY   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DONE   = 2'd2
  } kind_t;

  // Control broadcast to every match cell.
  typedef struct packed {
    logic init;   // arm the cell: alive, count zero
    logic shift;  // take the old byte from the neighbor
    logic cmp;    // compare held old byte with the broadcast new byte
    logic drain;  // take the run count from the neighbor
  } cell_ctl_t;

endpackage

// ===== src/dci_cell.sv =====
// One match cell: holds an old byte, tracks one candidate run.
`timescale 1ns / 1ps
module dci_cell #(
  parameter int CW = 13
) (
  input  logic               clk,
  input  logic               rst,
  input  dci_pkg::cell_ctl_t ctl,
  input  logic [7:0]         nbyte,
  input  logic [7:0]         in_byte,
  input  logic               in_val,
  input  logic [CW-1:0]      in_cnt,
  output logic [7:0]         obyte,
  output logic               oval,
  output logic [CW-1:0]      cnt,
  output logic               alive
);

  // run tracking and count drain
  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= 1'b0;
      oval  <= 1'b0;
    end else begin
      if (ctl.init) begin
        alive <= 1'b1;
        cnt   <= '0;
      end else begin
        if (ctl.cmp) begin
          if (alive && oval && (obyte == nbyte)) begin
            cnt <= cnt + CW'(1);
          end else begin
            alive <= 1'b0;
          end
        end
        if (ctl.drain) begin
          cnt <= in_cnt;
        end
      end
      // old bytes move one cell toward offset zero
      if (ctl.shift) begin
        obyte <= in_byte;
        oval  <= in_val;
      end
    end
  end

endmodule

// ===== src/dci_search.sv =====
// Longest-match search: byte stores, row of match cells, pass sequencer.
`timescale 1ns / 1ps
module dci_search #(
  parameter int MAX_BYTES = dci_pkg::MAX_BYTES,
  parameter int MIN_BEAT  = dci_pkg::MIN_BEAT,
  parameter int NUM_CELLS = dci_pkg::NUM_CELLS,
  localparam int AW = $clog2(MAX_BYTES),
  localparam int CW = $clog2(MAX_BYTES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          old_we,
  input  logic          new_we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [CW-1:0] old_count,
  input  logic [CW-1:0] new_count,
  input  logic          go,
  input  logic [CW-1:0] np,
  output logic          done,
  output logic [CW-1:0] match_len,
  output logic [AW-1:0] match_pos
);

  localparam int XW = CW + 2;
  localparam int DW = $clog2(NUM_CELLS);
  localparam logic [XW-1:0] KX = XW'(NUM_CELLS);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FLUSH, S_DRAIN} state_t;

  state_t        state;
  logic [XW-1:0] base;
  logic [XW-1:0] t;
  logic [DW-1:0] d;
  logic          pend;
  logic          pend_cmp;
  logic          pend_val;
  logic [CW-1:0] best_len;
  logic [AW-1:0] best_op;

  // byte stores
  logic [7:0]    old_mem [MAX_BYTES];
  logic [7:0]    new_mem [MAX_BYTES];
  logic [7:0]    old_rd;
  logic [7:0]    new_rd;
  logic [XW-1:0] old_ra;
  logic [XW-1:0] new_ra;

  always_ff @(posedge clk) begin
    if (old_we) begin
      old_mem[waddr] <= wdata;
    end
    if (new_we) begin
      new_mem[waddr] <= wdata;
    end
    old_rd <= old_mem[old_ra[AW-1:0]];
    new_rd <= new_mem[new_ra[AW-1:0]];
  end

  // issue side
  logic [XW-1:0] k;
  logic          issue_cmp;
  logic          stop;
  logic          any_alive;
  logic [XW-1:0] np_x;

  assign np_x      = XW'(np);
  assign k         = t - KX;
  assign issue_cmp = (t >= KX);
  assign stop      = issue_cmp && (!any_alive || ((np_x + k) >= XW'(new_count)));
  assign old_ra    = base + t;
  assign new_ra    = np_x + k;

  // cell row
  dci_pkg::cell_ctl_t ctl;
  logic [7:0]    byte_w  [NUM_CELLS+1];
  logic          val_w   [NUM_CELLS+1];
  logic [CW-1:0] cnt_w   [NUM_CELLS+1];
  logic [NUM_CELLS-1:0] alive_w;

  assign ctl.init  = (state == S_RUN) && (t == '0);
  assign ctl.shift = pend;
  assign ctl.cmp   = pend && pend_cmp;
  assign ctl.drain = (state == S_DRAIN);

  assign byte_w[NUM_CELLS] = old_rd;
  assign val_w[NUM_CELLS]  = pend_val;
  assign cnt_w[NUM_CELLS]  = '0;
  assign any_alive         = |alive_w;

  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    dci_cell #(.CW(CW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .nbyte   (new_rd),
      .in_byte (byte_w[j+1]),
      .in_val  (val_w[j+1]),
      .in_cnt  (cnt_w[j+1]),
      .obyte   (byte_w[j]),
      .oval    (val_w[j]),
      .cnt     (cnt_w[j]),
      .alive   (alive_w[j])
    );
  end

  // drain side: running best, strict compare keeps the earliest offset
  logic          upd;
  logic [CW-1:0] fin_len;
  logic [XW-1:0] cand_op;
  logic [XW-1:0] next_base;

  assign upd       = (cnt_w[0] > best_len);
  assign fin_len   = upd ? cnt_w[0] : best_len;
  assign cand_op   = base + XW'(d);
  assign next_base = base + KX;

  // pass sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pend     <= 1'b0;
      pend_cmp <= 1'b0;
      done     <= 1'b0;
    end else begin
      done     <= 1'b0;
      pend     <= 1'b0;
      pend_cmp <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            if (old_count == '0) begin
              done      <= 1'b1;
              match_len <= '0;
              match_pos <= '0;
            end else begin
              base     <= '0;
              t        <= '0;
              best_len <= '0;
              best_op  <= '0;
              state    <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (stop) begin
            state <= S_FLUSH;
          end else begin
            pend     <= 1'b1;
            pend_cmp <= issue_cmp;
            pend_val <= (old_ra < XW'(old_count));
            t        <= t + XW'(1);
          end
        end
        S_FLUSH: begin
          d     <= '0;
          state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (upd) begin
            best_len <= cnt_w[0];
            best_op  <= cand_op[AW-1:0];
          end
          d <= d + DW'(1);
          if (d == DW'(NUM_CELLS - 1)) begin
            if (next_base < XW'(old_count)) begin
              base  <= next_base;
              t     <= '0;
              state <= S_RUN;
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
              if (fin_len > CW'(MIN_BEAT)) begin
                match_len <= fin_len;
                match_pos <= upd ? cand_op[AW-1:0] : best_op;
              end else begin
                match_len <= '0;
                match_pos <= '0;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cmp_has_data: assert property (@(posedge clk) disable iff (rst)
    pend_cmp |-> pend) else $error("compare step without read data");
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_DRAIN || $past(state) == S_IDLE))
    else $error("done outside drain or idle");
  a_len_floor: assert property (@(posedge clk) disable iff (rst)
    (done && match_len != '0) |-> (match_len > CW'(MIN_BEAT)))
    else $error("match shorter than threshold reported");

endmodule

// ===== src/delta_copy_insert_matcher.sv =====
// Top level: buffer loading, greedy walk and record output.
//
//  channel   signals                               transfer
//  command   start, busy, cmd, data_byte           start && !busy at clk edge
//  record    strobe, kind, position, length, last  strobe high for one cycle
//
// Clear and load commands do not raise busy. A request reports a held copy or
// the end directly when one is pending; otherwise, for each walked new position,
// it runs a search of ceil(old_count/NUM_CELLS) passes over the cell row.
// Reset (rst, synchronous) empties both buffers; no clearing pass.
// busy is high while a request is in work; records cannot be stalled.
`timescale 1ns / 1ps
module delta_copy_insert_matcher #(
  parameter int MAX_BYTES = dci_pkg::MAX_BYTES,
  parameter int MIN_BEAT  = dci_pkg::MIN_BEAT,
  parameter int NUM_CELLS = dci_pkg::NUM_CELLS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [dci_pkg::CMD_W-1:0]   cmd,
  input  logic [7:0]                  data_byte,
  output logic                        strobe,
  output logic [dci_pkg::KIND_W-1:0]  kind,
  output logic [dci_pkg::POS_W-1:0]   position,
  output logic [dci_pkg::LEN_W-1:0]   length,
  output logic                        last
);

  localparam int AW = $clog2(MAX_BYTES);
  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int PW = dci_pkg::POS_W;
  localparam int LW = dci_pkg::LEN_W;

  typedef enum logic [1:0] {T_IDLE, T_STEP, T_WAIT} state_t;

  state_t        state;
  logic [CW-1:0] old_count;
  logic [CW-1:0] new_count;
  logic [CW-1:0] scan_pos;
  logic [AW-1:0] run_start;
  logic [CW-1:0] run_len;
  logic          held_copy_valid;
  logic [AW-1:0] held_copy_pos;
  logic [CW-1:0] held_copy_len;
  logic          finished;

  dci_pkg::cmd_t cmd_c;
  logic          acc;
  logic          old_we;
  logic          new_we;
  logic [AW-1:0] waddr;
  logic          sd_done;
  logic [CW-1:0] sd_len;
  logic [AW-1:0] sd_pos;
  logic          go;
  logic [CW-1:0] scan_next;

  assign busy      = (state != T_IDLE);
  assign cmd_c     = dci_pkg::cmd_t'(cmd);
  assign acc       = start && !busy;
  assign old_we    = acc && (cmd_c == dci_pkg::CMD_LOAD_OLD) && (old_count < CW'(MAX_BYTES));
  assign new_we    = acc && (cmd_c == dci_pkg::CMD_LOAD_NEW) && (new_count < CW'(MAX_BYTES));
  assign waddr     = old_we ? old_count[AW-1:0] : new_count[AW-1:0];
  assign go        = (state == T_STEP) && (scan_pos < new_count);
  assign scan_next = scan_pos + sd_len;

  dci_search #(
    .MAX_BYTES (MAX_BYTES),
    .MIN_BEAT  (MIN_BEAT),
    .NUM_CELLS (NUM_CELLS)
  ) u_search (
    .clk       (clk),
    .rst       (rst),
    .old_we    (old_we),
    .new_we    (new_we),
    .waddr     (waddr),
    .wdata     (data_byte),
    .old_count (old_count),
    .new_count (new_count),
    .go        (go),
    .np        (scan_pos),
    .done      (sd_done),
    .match_len (sd_len),
    .match_pos (sd_pos)
  );

  // walk state machine and record register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= T_IDLE;
      old_count       <= '0;
      new_count       <= '0;
      scan_pos        <= '0;
      run_start       <= '0;
      run_len         <= '0;
      held_copy_valid <= 1'b0;
      held_copy_pos   <= '0;
      held_copy_len   <= '0;
      finished        <= 1'b0;
      strobe          <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (acc) begin
            if (cmd_c == dci_pkg::CMD_REQUEST) begin
              priority if (finished) begin
                strobe   <= 1'b1;
                kind     <= dci_pkg::KIND_DONE;
                position <= '0;
                length   <= '0;
                last     <= 1'b1;
              end else if (held_copy_valid) begin
                strobe          <= 1'b1;
                kind            <= dci_pkg::KIND_COPY;
                position        <= PW'(held_copy_pos);
                length          <= LW'(held_copy_len);
                last            <= (scan_pos >= new_count);
                finished        <= (scan_pos >= new_count);
                held_copy_valid <= 1'b0;
                held_copy_pos   <= '0;
                held_copy_len   <= '0;
              end else begin
                state <= T_STEP;
              end
            end else begin
              // clear or load: restart the walk
              if (cmd_c == dci_pkg::CMD_CLEAR) begin
                old_count <= '0;
                new_count <= '0;
              end
              if (old_we) old_count <= old_count + CW'(1);
              if (new_we) new_count <= new_count + CW'(1);
              scan_pos        <= '0;
              run_start       <= '0;
              run_len         <= '0;
              held_copy_valid <= 1'b0;
              held_copy_pos   <= '0;
              held_copy_len   <= '0;
              finished        <= 1'b0;
            end
          end
        end
        T_STEP: begin
          if (scan_pos >= new_count) begin
            finished <= 1'b1;
            strobe   <= 1'b1;
            last     <= 1'b1;
            state    <= T_IDLE;
            if (run_len != '0) begin
              kind      <= dci_pkg::KIND_INSERT;
              position  <= PW'(run_start);
              length    <= LW'(run_len);
              run_len   <= '0;
              run_start <= '0;
            end else begin
              kind     <= dci_pkg::KIND_DONE;
              position <= '0;
              length   <= '0;
            end
          end else begin
            state <= T_WAIT;
          end
        end
        T_WAIT: begin
          if (sd_done) begin
            if (sd_len != '0) begin
              scan_pos <= scan_next;
              strobe   <= 1'b1;
              state    <= T_IDLE;
              if (run_len != '0) begin
                kind            <= dci_pkg::KIND_INSERT;
                position        <= PW'(run_start);
                length          <= LW'(run_len);
                last            <= 1'b0;
                run_len         <= '0;
                run_start       <= '0;
                held_copy_valid <= 1'b1;
                held_copy_pos   <= sd_pos;
                held_copy_len   <= sd_len;
              end else begin
                kind     <= dci_pkg::KIND_COPY;
                position <= PW'(sd_pos);
                length   <= LW'(sd_len);
                last     <= (scan_next >= new_count);
                finished <= (scan_next >= new_count);
              end
            end else begin
              // no copy here: grow the insert run by one byte
              if (run_len == '0) run_start <= scan_pos[AW-1:0];
              run_len  <= run_len + CW'(1);
              scan_pos <= scan_pos + CW'(1);
              state    <= T_STEP;
            end
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  a_held_no_run: assert property (@(posedge clk) disable iff (rst)
    held_copy_valid |-> (run_len == '0)) else $error("held copy with pending run");
  a_fin_no_held: assert property (@(posedge clk) disable iff (rst)
    finished |-> !held_copy_valid) else $error("finished with held copy");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sd_done |-> (state == T_WAIT)) else $error("search result outside wait");

endmodule
